/* src/etpf_pkg.sv */
package etpf_pkg;

   // Default frame length limit in bytes
   localparam int MAX_FRAME_BYTES_DEF = 65536;

   // Configuration register indexes
   localparam logic [1:0] CSR_FILTER_PORT     = 2'd0;
   localparam logic [1:0] CSR_MATCH_ETHERTYPE = 2'd1;
   localparam logic [1:0] CSR_MATCH_PROTOCOL  = 2'd2;

   // Configuration reset values
   localparam logic [15:0] FILTER_PORT_RST     = 16'd8080;
   localparam logic [15:0] MATCH_ETHERTYPE_RST = 16'h0800;
   localparam logic [7:0]  MATCH_PROTOCOL_RST  = 8'd6;

   // Byte positions within the frame
   localparam logic [15:0] POS_MAC_FIRST    = 16'd6;
   localparam logic [15:0] POS_MAC_LAST     = 16'd11;
   localparam logic [15:0] POS_ETYPE_HI     = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO     = 16'd13;
   localparam logic [15:0] ETH_HDR_BYTES    = 16'd14;
   localparam logic [15:0] POS_IP_PROTO     = 16'd23;
   localparam logic [15:0] POS_IP_SRC_FIRST = 16'd26;
   localparam logic [15:0] POS_IP_SRC_LAST  = 16'd29;
   localparam logic [15:0] POS_SATURATED    = 16'hFFFF;

   // Offsets within the TCP header
   localparam logic [15:0] TCP_DOFF_OFS = 16'd12;

   // Smallest legal IHL and data offset, in 32-bit words
   localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        payload_last;
      logic [47:0] src_mac;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } rsp_type;

endpackage

/* src/eth_ipv4_tcp_port_filter_unit.sv */
// Ethernet / IPv4 / TCP port filter.
// req channel: one frame byte per transfer (req_valid / req_stall), frame_last
// marks the final byte. Frames are checked for the configured ethertype and IP
// protocol, the IPv4 and TCP headers are skipped, and the TCP ports are compared
// against filter_port. Every TCP payload byte of a matching frame leaves on the
// rsp channel with the source MAC, source IP and both ports.
// csr channel: register writes (index, data); csr_ready is always high.
// Output: each payload byte is registered in the result register, or in the
// skid register under rsp_stall. Throughput: one byte per cycle unless stalled;
// all parsing is done in the transfer cycle against per-frame state registers.
// Stall: a two-entry output buffer (result register plus skid register) keeps
// req open while one result waits; req_stall rises only once both hold data.
// Reset (synchronous): frame state cleared, output buffer empty, registers at
// port 8080, ethertype 0x0800, protocol 6.
module eth_ipv4_tcp_port_filter_unit #(
   parameter int MAX_FRAME_BYTES = etpf_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  etpf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output etpf_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam logic [16:0] MAX_POS = 17'(MAX_FRAME_BYTES);

   // Configuration registers
   logic [15:0] filter_port_ff;
   logic [15:0] match_ethertype_ff;
   logic [7:0]  match_protocol_ff;

   // Per-frame state
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  etype_hi_ff, etype_hi_in;
   logic [5:0]  ip_hdr_ff, ip_hdr_in;
   logic [5:0]  tcp_hdr_ff, tcp_hdr_in;
   logic        rejected_ff, rejected_in;
   logic        matched_ff, matched_in;
   logic [47:0] mac_ff, mac_in;
   logic [31:0] ip_ff, ip_in;
   logic [15:0] sport_ff, sport_in;
   logic [15:0] dport_ff, dport_in;

   // Output buffer
   logic              out_valid_ff, out_valid_in;
   etpf_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   etpf_pkg::rsp_type skid_data_ff, skid_data_in;

   logic              accept;
   logic              emit;
   etpf_pkg::rsp_type result;
   logic [15:0]       tcp_start;
   logic [15:0]       tcp_payload;
   logic [3:0]        ihl;
   logic [3:0]        doff;
   logic [7:0]        b;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_port_ff     <= etpf_pkg::FILTER_PORT_RST;
         match_ethertype_ff <= etpf_pkg::MATCH_ETHERTYPE_RST;
         match_protocol_ff  <= etpf_pkg::MATCH_PROTOCOL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            etpf_pkg::CSR_FILTER_PORT:     filter_port_ff     <= csr_data;
            etpf_pkg::CSR_MATCH_ETHERTYPE: match_ethertype_ff <= csr_data;
            etpf_pkg::CSR_MATCH_PROTOCOL:  match_protocol_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Header parse for one byte
   always_comb begin
      pos_in      = pos_ff;
      etype_hi_in = etype_hi_ff;
      ip_hdr_in   = ip_hdr_ff;
      tcp_hdr_in  = tcp_hdr_ff;
      rejected_in = rejected_ff;
      matched_in  = matched_ff;
      mac_in      = mac_ff;
      ip_in       = ip_ff;
      sport_in    = sport_ff;
      dport_in    = dport_ff;
      emit        = 1'b0;
      b           = req_data.frame_byte;
      ihl         = b[3:0];
      doff        = b[7:4];
      tcp_start   = etpf_pkg::ETH_HDR_BYTES + {10'd0, ip_hdr_ff};
      tcp_payload = tcp_start + {10'd0, tcp_hdr_ff};

      if (accept) begin
         if (({1'b0, pos_ff} < MAX_POS) && !rejected_ff) begin
            // Ethernet and IPv4 fields at fixed positions
            if (pos_ff >= etpf_pkg::POS_MAC_FIRST && pos_ff <= etpf_pkg::POS_MAC_LAST) begin
               mac_in = {mac_ff[39:0], b};
            end else if (pos_ff == etpf_pkg::POS_ETYPE_HI) begin
               etype_hi_in = b;
            end else if (pos_ff == etpf_pkg::POS_ETYPE_LO) begin
               if ({etype_hi_ff, b} != match_ethertype_ff) rejected_in = 1'b1;
            end else if (pos_ff == etpf_pkg::ETH_HDR_BYTES) begin
               if (ihl < etpf_pkg::MIN_HDR_WORDS) rejected_in = 1'b1;
               else ip_hdr_in = {ihl, 2'b00};
            end else if (pos_ff == etpf_pkg::POS_IP_PROTO) begin
               if (b != match_protocol_ff) rejected_in = 1'b1;
            end else if (pos_ff >= etpf_pkg::POS_IP_SRC_FIRST &&
                         pos_ff <= etpf_pkg::POS_IP_SRC_LAST) begin
               ip_in = {ip_ff[23:0], b};
            end

            // TCP fields relative to the end of the IPv4 header
            if (!rejected_in && pos_ff > etpf_pkg::ETH_HDR_BYTES) begin
               if (pos_ff == tcp_start || pos_ff == tcp_start + 16'd1) begin
                  sport_in = {sport_ff[7:0], b};
               end else if (pos_ff == tcp_start + 16'd2 || pos_ff == tcp_start + 16'd3) begin
                  dport_in = {dport_ff[7:0], b};
                  if (pos_ff == tcp_start + 16'd3)
                     matched_in = (sport_ff == filter_port_ff) ||
                                  (dport_in == filter_port_ff);
               end else if (pos_ff == tcp_start + etpf_pkg::TCP_DOFF_OFS) begin
                  if (doff < etpf_pkg::MIN_HDR_WORDS) rejected_in = 1'b1;
                  else tcp_hdr_in = {doff, 2'b00};
               end else if (pos_ff > tcp_start + etpf_pkg::TCP_DOFF_OFS &&
                            pos_ff >= tcp_payload && matched_ff) begin
                  emit = 1'b1;
               end
            end
         end

         // Frame end clears all per-frame state; position saturates
         if (req_data.frame_last) begin
            pos_in      = '0;
            etype_hi_in = '0;
            ip_hdr_in   = '0;
            tcp_hdr_in  = '0;
            rejected_in = 1'b0;
            matched_in  = 1'b0;
            mac_in      = '0;
            ip_in       = '0;
            sport_in    = '0;
            dport_in    = '0;
         end else if (pos_ff != etpf_pkg::POS_SATURATED) begin
            pos_in = pos_ff + 16'd1;
         end
      end

      result.payload_byte = b;
      result.payload_last = req_data.frame_last;
      result.src_mac      = mac_ff;
      result.src_ip       = ip_ff;
      result.src_port     = sport_ff;
      result.dst_port     = dport_ff;
   end

   // Output buffer: result register with a skid register behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (emit) begin
         if (!out_valid_ff || !rsp_stall) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         etype_hi_ff   <= '0;
         ip_hdr_ff     <= '0;
         tcp_hdr_ff    <= '0;
         rejected_ff   <= 1'b0;
         matched_ff    <= 1'b0;
         mac_ff        <= '0;
         ip_ff         <= '0;
         sport_ff      <= '0;
         dport_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         etype_hi_ff   <= etype_hi_in;
         ip_hdr_ff     <= ip_hdr_in;
         tcp_hdr_ff    <= tcp_hdr_in;
         rejected_ff   <= rejected_in;
         matched_ff    <= matched_in;
         mac_ff        <= mac_in;
         ip_ff         <= ip_in;
         sport_ff      <= sport_in;
         dport_ff      <= dport_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* src/etpf_checker.sv */
module etpf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input etpf_pkg::rsp_type rsp_data
);

   // Output buffer is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A new result follows a req transfer
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result without a req transfer");

   // req stalls only while a result waits on the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with empty output");

endmodule

bind eth_ipv4_tcp_port_filter_unit etpf_checker u_etpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb_eth_ipv4_tcp_port_filter_unit.sv */
`timescale 1ns / 100ps

module tb_eth_ipv4_tcp_port_filter_unit;

   localparam int CLK_PERIOD   = 8;
   localparam int RANDOM_BYTES = 1750;
   localparam int RUN_LIMIT_NS = 10_000_000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_FRAME   = 65540;
   localparam int MIN_TCP_HDR  = 54;
   localparam int PHASES       = 5;

   // Register index with no register behind it
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   etpf_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   etpf_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [15:0]       csr_data  = '0;

   eth_ipv4_tcp_port_filter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Configuration mirror
   logic [15:0] cfg_port;
   logic [15:0] cfg_etype;
   logic [7:0]  cfg_proto;

   // Per-frame parser state mirror
   logic [15:0] pos;
   logic [15:0] etype_seen;
   logic [5:0]  ip_hdr_len;
   logic [5:0]  tcp_hdr_len;
   logic        rejected;
   logic        matched;
   logic [47:0] mac_seen;
   logic [31:0] ip_seen;
   logic [15:0] sport_seen;
   logic [15:0] dport_seen;
   logic [7:0]  proto_seen;

   etpf_pkg::rsp_type pending_payload[$];
   logic [7:0]        frame_bytes[$];

   int  errors       = 0;
   int  bytes_sent   = 0;
   int  frames_sent  = 0;
   int  bytes_seen   = 0;
   bit  idle_on      = 1'b1;
   int  stall_hold   = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout at %0t", $time);
      $display("end of test: mismatches");
      $finish;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void clear_frame_state();
      pos         = '0;
      etype_seen  = '0;
      ip_hdr_len  = '0;
      tcp_hdr_len = '0;
      rejected    = 1'b0;
      matched     = 1'b0;
      mac_seen    = '0;
      ip_seen     = '0;
      sport_seen  = '0;
      dport_seen  = '0;
      proto_seen  = '0;
   endfunction

   // Parser mirror: advance by one accepted byte, queue a payload byte if due
   function automatic void parse_byte(input logic [7:0] b, input logic last);
      int                p;
      int                t;
      etpf_pkg::rsp_type item;
      p = int'(pos);
      if (p < etpf_pkg::MAX_FRAME_BYTES_DEF && !rejected) begin
         // Ethernet and IPv4 header fields
         if (p >= etpf_pkg::POS_MAC_FIRST && p <= etpf_pkg::POS_MAC_LAST) begin
            mac_seen = {mac_seen[39:0], b};
         end else if (p == etpf_pkg::POS_ETYPE_HI || p == etpf_pkg::POS_ETYPE_LO) begin
            etype_seen = {etype_seen[7:0], b};
            if (p == etpf_pkg::POS_ETYPE_LO && etype_seen != cfg_etype) rejected = 1'b1;
         end else if (p == etpf_pkg::ETH_HDR_BYTES) begin
            if (b[3:0] < etpf_pkg::MIN_HDR_WORDS) rejected = 1'b1;
            else ip_hdr_len = {b[3:0], 2'b00};
         end else if (p == etpf_pkg::POS_IP_PROTO) begin
            proto_seen = b;
            if (b != cfg_proto) rejected = 1'b1;
         end else if (p >= etpf_pkg::POS_IP_SRC_FIRST && p <= etpf_pkg::POS_IP_SRC_LAST) begin
            ip_seen = {ip_seen[23:0], b};
         end

         // TCP header and payload
         if (!rejected && p > etpf_pkg::ETH_HDR_BYTES) begin
            t = int'(etpf_pkg::ETH_HDR_BYTES) + int'(ip_hdr_len);
            if (p == t || p == t + 1) begin
               sport_seen = {sport_seen[7:0], b};
            end else if (p == t + 2 || p == t + 3) begin
               dport_seen = {dport_seen[7:0], b};
               if (p == t + 3) matched = (sport_seen == cfg_port) || (dport_seen == cfg_port);
            end else if (p == t + int'(etpf_pkg::TCP_DOFF_OFS)) begin
               if (b[7:4] < etpf_pkg::MIN_HDR_WORDS) rejected = 1'b1;
               else tcp_hdr_len = {b[7:4], 2'b00};
            end else if (p > t + int'(etpf_pkg::TCP_DOFF_OFS) &&
                         p >= t + int'(tcp_hdr_len) && matched) begin
               item.payload_byte = b;
               item.payload_last = last;
               item.src_mac      = mac_seen;
               item.src_ip       = ip_seen;
               item.src_port     = sport_seen;
               item.dst_port     = dport_seen;
               pending_payload.push_back(item);
            end
         end
      end

      if (last) clear_frame_state();
      else if (pos != etpf_pkg::POS_SATURATED) pos = pos + 16'd1;
   endfunction

   // One byte transfer on req, then update the mirror
   task automatic send_byte(input logic [7:0] b, input logic last);
      int n;
      n = pick_gap();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_byte(b, last);
      bytes_sent++;
   endtask

   // Send the first len bytes of the built frame, last mark on the final one
   task automatic send_frame(input int len);
      int i;
      if (len > frame_bytes.size()) len = frame_bytes.size();
      for (i = 0; i < len; i++) send_byte(frame_bytes[i], i == len - 1);
      frames_sent++;
   endtask

   // Build an Ethernet / IPv4 / TCP frame with random filler
   task automatic make_frame(input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [15:0] sport,
                             input logic [15:0] dport, input logic [3:0] doff,
                             input int pay_len);
      logic [3:0] version;
      int         i;
      frame_bytes.delete();
      repeat (12) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(etype[15:8]);
      frame_bytes.push_back(etype[7:0]);
      version = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd4;
      frame_bytes.push_back({version, ihl});
      repeat (8) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(proto);
      repeat (10) frame_bytes.push_back(8'($urandom));  // checksum, src and dst IP
      for (i = 5; i < ihl; i++) repeat (4) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(sport[15:8]);
      frame_bytes.push_back(sport[7:0]);
      frame_bytes.push_back(dport[15:8]);
      frame_bytes.push_back(dport[7:0]);
      repeat (8) frame_bytes.push_back(8'($urandom));   // seq and ack
      frame_bytes.push_back({doff, 4'($urandom)});
      repeat (7) frame_bytes.push_back(8'($urandom));   // flags, window, csum, urg
      for (i = 5; i < doff; i++) repeat (4) frame_bytes.push_back(8'($urandom));
      repeat (pay_len) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         etpf_pkg::CSR_FILTER_PORT:     cfg_port  = val;
         etpf_pkg::CSR_MATCH_ETHERTYPE: cfg_etype = val;
         etpf_pkg::CSR_MATCH_PROTOCOL:  cfg_proto = val[7:0];
         default: ;
      endcase
   endtask

   // Drop req valid and let every queued payload byte drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_payload.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] port, input logic [15:0] etype,
                             input logic [15:0] proto);
      wait_idle();
      write_csr(etpf_pkg::CSR_FILTER_PORT, port);
      write_csr(etpf_pkg::CSR_MATCH_ETHERTYPE, etype);
      write_csr(etpf_pkg::CSR_MATCH_PROTOCOL, proto);
   endtask

   // Result stall: random runs of stall and no stall
   always @(posedge clock) begin
      int n;
      if (stall_hold != 0) begin
         stall_hold--;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else begin
         n = pick_gap();
         rsp_stall  <= (n != 0);
         stall_hold = (n != 0) ? n - 1 : $urandom_range(0, 4);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Compare each result transfer with the oldest queued payload byte
   always @(posedge clock) begin
      etpf_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_payload.size() == 0) begin
            $display("%0t: unexpected payload transfer, expected none, actual %h",
                     $time, rsp_data);
            errors++;
         end else begin
            want = pending_payload.pop_front();
            check_field("payload_byte", 64'(want.payload_byte),
                        64'(rsp_data.payload_byte));
            check_field("payload_last", 64'(want.payload_last),
                        64'(rsp_data.payload_last));
            check_field("src_mac", 64'(want.src_mac), 64'(rsp_data.src_mac));
            check_field("src_ip", 64'(want.src_ip), 64'(rsp_data.src_ip));
            check_field("src_port", 64'(want.src_port), 64'(rsp_data.src_port));
            check_field("dst_port", 64'(want.dst_port), 64'(rsp_data.dst_port));
            bytes_seen++;
         end
      end
   end

   // Reset values: match on either port, miss, header-only, extremes in payload
   task automatic test_reset_defaults();
      make_frame(cfg_etype, 4'd5, cfg_proto, 16'($urandom), cfg_port, 4'd5, 3);
      frame_bytes[frame_bytes.size() - 2] = 8'h00;
      frame_bytes[frame_bytes.size() - 1] = 8'hFF;
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port, 16'($urandom), 4'd5, 3);
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port + 16'd1, cfg_port + 16'd2, 4'd5, 3);
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port, cfg_port, 4'd5, 0);
      send_frame(frame_bytes.size());
   endtask

   // Rejects on ethertype, protocol and short IHL or data offset
   task automatic test_header_rejects();
      make_frame(cfg_etype ^ 16'h0001, 4'd5, cfg_proto, cfg_port, cfg_port, 4'd5, 4);
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd5, cfg_proto ^ 8'h80, cfg_port, cfg_port, 4'd5, 4);
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd4, cfg_proto, cfg_port, cfg_port, 4'd5, 4);
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd0, cfg_proto, cfg_port, cfg_port, 4'd5, 4);
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port, cfg_port, 4'd4, 4);
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port, cfg_port, 4'd0, 4);
      send_frame(frame_bytes.size());
   endtask

   // Largest headers, unchecked version nibble, frames cut inside the headers
   task automatic test_header_lengths();
      make_frame(cfg_etype, 4'd15, cfg_proto, 16'($urandom), cfg_port, 4'd15, 2);
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port, 16'($urandom), 4'd5, 2);
      frame_bytes[etpf_pkg::ETH_HDR_BYTES] = {4'hF, 4'd5};
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port, cfg_port, 4'd5, 4);
      send_frame(20);
      send_frame(40);
      send_frame(1);
   endtask

   // Frame longer than the position counter, no idling
   task automatic test_position_saturation();
      idle_on = 1'b0;
      wait_idle();
      make_frame(cfg_etype, 4'd5, cfg_proto, 16'($urandom), cfg_port, 4'd5,
                 LONG_FRAME - MIN_TCP_HDR);
      send_frame(frame_bytes.size());
      make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port, 16'($urandom), 4'd5, 3);
      send_frame(frame_bytes.size());
      idle_on = 1'b1;
   endtask

   // Register extremes and a write to the unused index
   task automatic test_config_extremes();
      int k;
      for (k = 0; k < 3; k++) begin
         case (k)
            0: set_config(16'h0000, 16'h0000, 16'h0000);
            1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
            default: set_config(16'd443, 16'h86DD, {8'($urandom), 8'd17});
         endcase
         make_frame(cfg_etype, 4'd5, cfg_proto, 16'($urandom), cfg_port, 4'd6, 3);
         send_frame(frame_bytes.size());
         make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port + 16'd1, cfg_port - 16'd1,
                    4'd5, 2);
         send_frame(frame_bytes.size());
         make_frame(etpf_pkg::MATCH_ETHERTYPE_RST, 4'd5, etpf_pkg::MATCH_PROTOCOL_RST,
                    etpf_pkg::FILTER_PORT_RST, etpf_pkg::FILTER_PORT_RST, 4'd5, 2);
         send_frame(frame_bytes.size());
      end
      wait_idle();
      write_csr(CSR_SPARE, 16'($urandom));
      make_frame(cfg_etype, 4'd5, cfg_proto, cfg_port, 16'($urandom), 4'd5, 2);
      send_frame(frame_bytes.size());
   endtask

   // Mostly well-formed frames, plus bad headers, truncation and noise
   task automatic random_frame();
      int          kind;
      int          len;
      int          pay;
      logic [3:0]  ihl;
      logic [3:0]  doff;
      logic [15:0] sp;
      logic [15:0] dp;
      logic [15:0] et;
      logic [7:0]  pr;
      kind = $urandom_range(0, 99);
      ihl  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      doff = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      pay  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
      sp   = 16'($urandom);
      dp   = 16'($urandom);
      case ($urandom_range(0, 3))
         0: sp = cfg_port;
         1: dp = cfg_port;
         2: begin
            sp = cfg_port;
            dp = cfg_port;
         end
         default: ;
      endcase
      et = cfg_etype;
      pr = cfg_proto;
      if (kind >= 70 && kind < 80) begin
         case ($urandom_range(0, 3))
            0: et = cfg_etype ^ (16'd1 << $urandom_range(0, 15));
            1: pr = cfg_proto ^ (8'd1 << $urandom_range(0, 7));
            2: ihl = 4'($urandom_range(0, 4));
            default: doff = 4'($urandom_range(0, 4));
         endcase
      end
      make_frame(et, ihl, pr, sp, dp, doff, pay);
      len = frame_bytes.size();
      if (kind >= 80 && kind < 90) begin
         len = $urandom_range(1, len - 1);
      end else if (kind >= 90) begin
         frame_bytes.delete();
         len = $urandom_range(1, 80);
         repeat (len) frame_bytes.push_back(8'($urandom));
      end
      send_frame(len);
   endtask

   task automatic test_random_traffic();
      int phase;
      int target;
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            set_config(etpf_pkg::FILTER_PORT_RST, etpf_pkg::MATCH_ETHERTYPE_RST,
                       16'(etpf_pkg::MATCH_PROTOCOL_RST));
         end else begin
            set_config(($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                       ($urandom_range(0, 1) == 0) ? etpf_pkg::MATCH_ETHERTYPE_RST
                                                   : 16'($urandom),
                       ($urandom_range(0, 1) == 0) ? 16'(etpf_pkg::MATCH_PROTOCOL_RST)
                                                   : 16'($urandom));
         end
         target = bytes_sent + RANDOM_BYTES / PHASES;
         while (bytes_sent < target) begin
            idle_on = ($urandom_range(0, 6) != 0);
            random_frame();
         end
         idle_on = 1'b1;
      end
   endtask

   // Test sequence
   initial begin
      cfg_port  = etpf_pkg::FILTER_PORT_RST;
      cfg_etype = etpf_pkg::MATCH_ETHERTYPE_RST;
      cfg_proto = etpf_pkg::MATCH_PROTOCOL_RST;
      clear_frame_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_header_rejects();
      test_header_lengths();
      test_position_saturation();
      test_config_extremes();
      test_random_traffic();
      wait_idle();

      $display("covered %0d frames, %0d bytes in, %0d payload bytes checked",
               frames_sent, bytes_sent, bytes_seen);
      $display("port, ethertype and protocol filters at reset, extreme and random settings");
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/etpf_pkg.sv
src/eth_ipv4_tcp_port_filter_unit.sv
src/etpf_checker.sv
tb/tb_eth_ipv4_tcp_port_filter_unit.sv
